// ----- rtl/slt_pkg.sv -----
// types and constants shared by the sorted priority log table
// no dependencies; used by slt_mem, slt_seq and sorted_priority_log_table
`timescale 1ns / 1ps

package slt_pkg;

    localparam int LETTER_W   = 5;
    localparam int NUMBER_W   = 14;
    localparam int PRIO_W     = 10;
    localparam int INDEX_W    = 5;
    localparam int OP_W       = 2;
    localparam int TOTAL_W    = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_PURGE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'd1;

    localparam logic [LETTER_W-1:0] LIMIT_RESET  = 5'd4;
    localparam logic [PRIO_W-1:0]   THRESH_RESET = 10'd300;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [LETTER_W-1:0] entry_letter;
        logic [NUMBER_W-1:0] entry_number;
        logic [PRIO_W-1:0]   entry_priority;
        logic [INDEX_W-1:0]  read_index;
    } t_in_item;

    typedef struct packed {
        logic                status;
        logic [TOTAL_W-1:0]  fill_level;
        logic [TOTAL_W-1:0]  critical_total;
        logic [TOTAL_W-1:0]  normal_total;
        logic [LETTER_W-1:0] out_letter;
        logic [NUMBER_W-1:0] out_number;
        logic [PRIO_W-1:0]   out_priority;
        logic                out_critical;
        logic                out_valid;
    } t_out_item;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic [NUMBER_W-1:0] number;
        logic [PRIO_W-1:0]   prio;
    } t_entry;

    typedef struct packed {
        logic [LETTER_W-1:0] critical_letter_limit;
        logic [PRIO_W-1:0]   purge_threshold;
    } t_cfg;

    // handshake between the sequencer and the output register
    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_stat;

endpackage

// ----- rtl/slt_mem.sv -----
// record store: one write port, one read port with registered read data
// depends on slt_pkg for the entry type
`timescale 1ns / 1ps

module slt_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  slt_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output slt_pkg::t_entry o_rdata
);

    slt_pkg::t_entry r_mem [DEPTH];
    slt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/slt_seq.sv -----
// sequencer: walks the record store for insert, purge, read and recount
// depends on slt_pkg; drives the ports of slt_mem
`timescale 1ns / 1ps

module slt_seq #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int CW    = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  slt_pkg::t_in_item   i_item,
    input  slt_pkg::t_cfg       i_cfg,
    input  logic                i_limit_wr,
    input  logic                i_res_ready,
    output slt_pkg::t_seq_stat  o_stat,
    output slt_pkg::t_out_item  o_result,
    output logic                o_mem_we,
    output logic [AW-1:0]       o_mem_waddr,
    output slt_pkg::t_entry     o_mem_wdata,
    output logic [AW-1:0]       o_mem_raddr,
    input  slt_pkg::t_entry     i_mem_rdata
);

    localparam int IW = (CW > slt_pkg::INDEX_W) ? CW : slt_pkg::INDEX_W;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISP     = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_INS      = 7'b0001000,
        S_INS_LAST = 7'b0010000,
        S_PRG      = 7'b0100000,
        S_FIN      = 7'b1000000
    } t_state;

    // read data is captured in S_DISP the cycle after its address goes out
    t_state            r_state, n_state;
    logic              r_rd_pend, n_rd_pend;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_crit, n_crit;
    logic              r_recount, n_recount;
    slt_pkg::t_in_item r_item, n_item;
    logic [CW-1:0]     r_ptr, n_ptr;
    logic [CW-1:0]     r_wp, n_wp;
    logic              r_status, n_status;
    slt_pkg::t_entry   r_rd_ent, n_rd_ent;
    logic              r_rd_crit, n_rd_crit;
    logic              r_rd_valid, n_rd_valid;

    slt_pkg::t_entry   new_ent;
    logic              new_crit;
    logic              rd_crit;
    logic              goes_before;
    logic              keep;
    logic [CW-1:0]     wp_next;
    logic [IW-1:0]     idx_ext;
    logic [IW-1:0]     cnt_ext;

    assign new_ent.letter = r_item.entry_letter;
    assign new_ent.number = r_item.entry_number;
    assign new_ent.prio   = r_item.entry_priority;
    assign new_crit    = r_item.entry_letter <= i_cfg.critical_letter_limit;
    assign rd_crit     = i_mem_rdata.letter <= i_cfg.critical_letter_limit;
    assign goes_before = (r_item.entry_letter < i_mem_rdata.letter) ||
                         ((r_item.entry_letter == i_mem_rdata.letter) &&
                          (r_item.entry_priority > i_mem_rdata.prio));
    assign keep        = i_mem_rdata.prio >= i_cfg.purge_threshold;
    assign wp_next     = r_wp + CW'(keep);
    assign idx_ext     = IW'(r_item.read_index);
    assign cnt_ext     = IW'(r_count);

    always_comb begin
        n_state     = r_state;
        n_rd_pend   = 1'b0;
        n_count     = r_count;
        n_crit      = r_crit;
        n_recount   = r_recount;
        n_item      = r_item;
        n_ptr       = r_ptr;
        n_wp        = r_wp;
        n_status    = r_status;
        n_rd_ent    = r_rd_ent;
        n_rd_crit   = r_rd_crit;
        n_rd_valid  = r_rd_valid;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = i_mem_rdata;
        o_mem_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item     = i_item;
                    n_status   = 1'b0;
                    n_rd_ent   = '0;
                    n_rd_crit  = 1'b0;
                    n_rd_valid = 1'b0;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                if (r_rd_pend) begin
                    // data of a read transaction arrives here
                    n_rd_ent   = i_mem_rdata;
                    n_rd_crit  = rd_crit;
                    n_rd_valid = 1'b1;
                    n_state    = S_FIN;
                end else if (r_recount) begin
                    // limit changed since the last transaction
                    n_recount = 1'b0;
                    n_crit    = '0;
                    if (r_count != '0) begin
                        o_mem_raddr = '0;
                        n_ptr       = CW'(1);
                        n_state     = S_SCAN;
                    end
                end else begin
                    case (r_item.operation)
                        slt_pkg::OP_INSERT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = 1'b1;
                                n_state  = S_FIN;
                            end else begin
                                n_count = r_count + CW'(1);
                                n_crit  = r_crit + CW'(new_crit);
                                if (r_count == '0) begin
                                    o_mem_we    = 1'b1;
                                    o_mem_waddr = '0;
                                    o_mem_wdata = new_ent;
                                    n_state     = S_FIN;
                                end else begin
                                    o_mem_raddr = AW'(r_count - CW'(1));
                                    n_ptr       = r_count;
                                    n_state     = S_INS;
                                end
                            end
                        end
                        slt_pkg::OP_PURGE: begin
                            if (r_count != '0) begin
                                o_mem_raddr = '0;
                                n_ptr       = CW'(1);
                                n_wp        = '0;
                                n_crit      = '0;
                                n_state     = S_PRG;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                        slt_pkg::OP_READ: begin
                            if (idx_ext < cnt_ext) begin
                                o_mem_raddr = AW'(idx_ext);
                                n_rd_pend   = 1'b1;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_crit = r_crit + CW'(rd_crit);
                if (r_ptr < r_count) begin
                    o_mem_raddr = AW'(r_ptr);
                    n_ptr       = r_ptr + CW'(1);
                end else begin
                    n_state = S_DISP;
                end
            end
            S_INS: begin
                // r_ptr is the hole; the data is the entry just below it
                o_mem_we = 1'b1;
                o_mem_waddr = AW'(r_ptr);
                if (goes_before) begin
                    o_mem_wdata = i_mem_rdata;
                    if (r_ptr == CW'(1)) begin
                        n_state = S_INS_LAST;
                    end else begin
                        o_mem_raddr = AW'(r_ptr - CW'(2));
                        n_ptr       = r_ptr - CW'(1);
                    end
                end else begin
                    o_mem_wdata = new_ent;
                    n_state     = S_FIN;
                end
            end
            S_INS_LAST: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = '0;
                o_mem_wdata = new_ent;
                n_state     = S_FIN;
            end
            S_PRG: begin
                o_mem_we    = keep;
                o_mem_waddr = AW'(r_wp);
                o_mem_wdata = i_mem_rdata;
                n_wp        = wp_next;
                n_crit      = r_crit + CW'(keep & rd_crit);
                if (r_ptr < r_count) begin
                    o_mem_raddr = AW'(r_ptr);
                    n_ptr       = r_ptr + CW'(1);
                end else begin
                    n_count = wp_next;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_limit_wr) begin
            n_recount = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_pend <= 1'b0;
            r_count   <= '0;
            r_crit    <= '0;
            r_recount <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= n_rd_pend;
            r_count   <= n_count;
            r_crit    <= n_crit;
            r_recount <= n_recount;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_ptr      <= n_ptr;
        r_wp       <= n_wp;
        r_status   <= n_status;
        r_rd_ent   <= n_rd_ent;
        r_rd_crit  <= n_rd_crit;
        r_rd_valid <= n_rd_valid;
    end

    assign o_stat.busy = r_state != S_IDLE;
    assign o_stat.done = (r_state == S_FIN) && i_res_ready;

    assign o_result.status         = r_status;
    assign o_result.fill_level     = slt_pkg::TOTAL_W'(r_count);
    assign o_result.critical_total = slt_pkg::TOTAL_W'(r_crit);
    assign o_result.normal_total   = slt_pkg::TOTAL_W'(r_count - r_crit);
    assign o_result.out_letter     = r_rd_ent.letter;
    assign o_result.out_number     = r_rd_ent.number;
    assign o_result.out_priority   = r_rd_ent.prio;
    assign o_result.out_critical   = r_rd_crit;
    assign o_result.out_valid      = r_rd_valid;

endmodule

// ----- rtl/sorted_priority_log_table.sv -----
// Sorted priority log table: holds up to DEPTH error records in one memory, ordered by
// letter ascending, then priority descending, equal keys in arrival order. One transaction
// is worked on at a time; the memory's single read port walks one entry per cycle. An insert
// into a non-empty table moves up each record that sorts behind the new one, a purge walks
// every record, and an insert into a full table is dropped with status set. The first
// transaction after critical_letter_limit is written first recounts the critical records.
// A finished result waits in the output register, and the next transaction is accepted
// meanwhile. No clearing pass is needed after reset.
// depends on slt_pkg, slt_mem and slt_seq
`timescale 1ns / 1ps

module sorted_priority_log_table #(
    parameter int DEPTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  slt_pkg::t_in_item                  i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output slt_pkg::t_out_item                 o_out_item,
    input  logic                               i_cfg_we,
    input  logic [slt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [slt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    slt_pkg::t_cfg      r_cfg;
    logic               limit_wr;
    logic               r_out_valid;
    slt_pkg::t_out_item r_out_item;
    logic               res_ready;
    slt_pkg::t_seq_stat seq_stat;
    slt_pkg::t_out_item seq_result;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    slt_pkg::t_entry    mem_wdata;
    logic [AW-1:0]      mem_raddr;
    slt_pkg::t_entry    mem_rdata;

    assign limit_wr = i_cfg_we && (i_cfg_index == slt_pkg::CFG_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.critical_letter_limit <= slt_pkg::LIMIT_RESET;
            r_cfg.purge_threshold       <= slt_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                slt_pkg::CFG_LIMIT: begin
                    r_cfg.critical_letter_limit <= i_cfg_data[slt_pkg::LETTER_W-1:0];
                end
                slt_pkg::CFG_THRESH: begin
                    r_cfg.purge_threshold <= i_cfg_data[slt_pkg::PRIO_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // result register frees when empty or taken this cycle
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_stat.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_stat.done) begin
            r_out_item <= seq_result;
        end
    end

    slt_seq #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && !seq_stat.busy),
        .i_item      (i_in_item),
        .i_cfg       (r_cfg),
        .i_limit_wr  (limit_wr),
        .i_res_ready (res_ready),
        .o_stat      (seq_stat),
        .o_result    (seq_result),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    slt_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_in_stall  = seq_stat.busy;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- verif/tb.sv -----
// testbench for sorted_priority_log_table: directed table, then random phases per config
// predicts unfixed reports with its own sorted table model; needs slt_pkg and the rtl
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH     = 32;
    localparam int SETTLE    = 2 * DEPTH + 8;
    localparam int LIMIT     = 1000000;
    localparam int LONG_HOLD = 300;
    localparam int N_PHASES  = 8;

    localparam logic [slt_pkg::OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        slt_pkg::t_in_item  txn;
        logic               fixed;
        slt_pkg::t_out_item report;
    } t_dir_row;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    slt_pkg::t_in_item              in_item   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    slt_pkg::t_out_item             out_item;
    logic                           cfg_we    = 1'b0;
    logic [slt_pkg::CFG_IDX_W-1:0]  cfg_index = slt_pkg::CFG_LIMIT;
    logic [slt_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // shadow copy of the sorted table and its config
    logic [slt_pkg::LETTER_W-1:0] log_letter [DEPTH];
    logic [slt_pkg::NUMBER_W-1:0] log_number [DEPTH];
    logic [slt_pkg::PRIO_W-1:0]   log_prio   [DEPTH];
    int                           log_fill    = 0;
    logic [slt_pkg::LETTER_W-1:0] crit_limit  = slt_pkg::LIMIT_RESET;
    logic [slt_pkg::PRIO_W-1:0]   purge_floor = slt_pkg::THRESH_RESET;

    int unsigned ph_limit  [N_PHASES] = '{0, 25, 31, 12, 0, 20, 4, 7};
    int unsigned ph_thresh [N_PHASES] = '{0, 1000, 1023, 500, 1023, 100, 300, 650};
    int unsigned ph_ins    [N_PHASES] = '{80, 60, 50, 90, 55, 75, 65, 70};
    int unsigned ph_items  [N_PHASES] = '{180, 180, 180, 180, 180, 180, 180, 180};

    slt_pkg::t_out_item due_reports [$];
    t_dir_row           dir_rows [$];
    slt_pkg::t_out_item want_rep;
    int                 mismatches     = 0;
    int                 cycles         = 0;
    int                 burst_left     = 0;
    bit                 want_long_hold = 1'b0;

    sorted_priority_log_table #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("sorted_priority_log_table test failed");
            $finish;
        end
    end

    function automatic slt_pkg::t_out_item apply_log_op(slt_pkg::t_in_item txn);
        slt_pkg::t_out_item rep;
        int pos, k, kept, crit;
        rep = '0;
        case (txn.operation)
            slt_pkg::OP_INSERT: begin
                if (log_fill >= DEPTH) begin
                    rep.status = 1'b1;
                end else begin
                    // new record goes behind older ones with the same key
                    pos = 0;
                    while (pos < log_fill &&
                           !(txn.entry_letter < log_letter[pos] ||
                             (txn.entry_letter == log_letter[pos] &&
                              txn.entry_priority > log_prio[pos])))
                        pos++;
                    for (k = log_fill; k > pos; k--) begin
                        log_letter[k] = log_letter[k-1];
                        log_number[k] = log_number[k-1];
                        log_prio[k]   = log_prio[k-1];
                    end
                    log_letter[pos] = txn.entry_letter;
                    log_number[pos] = txn.entry_number;
                    log_prio[pos]   = txn.entry_priority;
                    log_fill++;
                end
            end
            slt_pkg::OP_PURGE: begin
                kept = 0;
                for (k = 0; k < log_fill; k++) begin
                    if (log_prio[k] >= purge_floor) begin
                        log_letter[kept] = log_letter[k];
                        log_number[kept] = log_number[k];
                        log_prio[kept]   = log_prio[k];
                        kept++;
                    end
                end
                log_fill = kept;
            end
            slt_pkg::OP_READ: begin
                if (txn.read_index < log_fill) begin
                    rep.out_letter   = log_letter[txn.read_index];
                    rep.out_number   = log_number[txn.read_index];
                    rep.out_priority = log_prio[txn.read_index];
                    rep.out_critical = (log_letter[txn.read_index] <= crit_limit);
                    rep.out_valid    = 1'b1;
                end
            end
            default: ;
        endcase
        crit = 0;
        for (k = 0; k < log_fill; k++)
            if (log_letter[k] <= crit_limit)
                crit++;
        rep.fill_level     = slt_pkg::TOTAL_W'(log_fill);
        rep.critical_total = slt_pkg::TOTAL_W'(crit);
        rep.normal_total   = slt_pkg::TOTAL_W'(log_fill - crit);
        return rep;
    endfunction

    function automatic slt_pkg::t_in_item mk_txn(logic [slt_pkg::OP_W-1:0] op, int letter,
                                                 int number, int prio, int idx);
        slt_pkg::t_in_item t;
        t.operation      = op;
        t.entry_letter   = slt_pkg::LETTER_W'(letter);
        t.entry_number   = slt_pkg::NUMBER_W'(number);
        t.entry_priority = slt_pkg::PRIO_W'(prio);
        t.read_index     = slt_pkg::INDEX_W'(idx);
        return t;
    endfunction

    function automatic slt_pkg::t_out_item mk_report(int fill, int crit, int norm, int letter,
                                                     int number, int prio, bit critb,
                                                     bit hit);
        slt_pkg::t_out_item r;
        r.status         = 1'b0;
        r.fill_level     = slt_pkg::TOTAL_W'(fill);
        r.critical_total = slt_pkg::TOTAL_W'(crit);
        r.normal_total   = slt_pkg::TOTAL_W'(norm);
        r.out_letter     = slt_pkg::LETTER_W'(letter);
        r.out_number     = slt_pkg::NUMBER_W'(number);
        r.out_priority   = slt_pkg::PRIO_W'(prio);
        r.out_critical   = critb;
        r.out_valid      = hit;
        return r;
    endfunction

    function automatic void add_row(slt_pkg::t_in_item txn, bit fixed,
                                    slt_pkg::t_out_item rep);
        t_dir_row row;
        row.txn    = txn;
        row.fixed  = fixed;
        row.report = rep;
        dir_rows.push_back(row);
    endfunction

    function automatic slt_pkg::t_in_item rand_txn(int unsigned ins_pct);
        slt_pkg::t_in_item t;
        int unsigned r, rest, span, p;
        r    = $urandom_range(0, 99);
        span = 100 - ins_pct;
        if (r < ins_pct) begin
            t.operation = slt_pkg::OP_INSERT;
        end else begin
            rest = r - ins_pct;
            if (rest < span * 6 / 10)
                t.operation = slt_pkg::OP_READ;
            else if (rest < span * 9 / 10)
                t.operation = slt_pkg::OP_PURGE;
            else
                t.operation = OP_SPARE;
        end
        // a narrow letter range makes equal keys common
        p = $urandom_range(0, 9);
        if (p < 6)
            t.entry_letter = slt_pkg::LETTER_W'($urandom_range(0, 7));
        else if (p < 9)
            t.entry_letter = slt_pkg::LETTER_W'($urandom_range(0, 25));
        else
            t.entry_letter = slt_pkg::LETTER_W'($urandom_range(0, 31));
        t.entry_number = slt_pkg::NUMBER_W'($urandom_range(0, 16383));
        p = $urandom_range(0, 9);
        if (p < 4)
            t.entry_priority = slt_pkg::PRIO_W'($urandom_range(0, 4) * 250);
        else if (p < 5)
            t.entry_priority = slt_pkg::PRIO_W'(int'(purge_floor) +
                                                int'($urandom_range(0, 2)) - 1);
        else if (p < 9)
            t.entry_priority = slt_pkg::PRIO_W'($urandom_range(0, 1000));
        else
            t.entry_priority = slt_pkg::PRIO_W'($urandom_range(0, 1023));
        if ($urandom_range(0, 9) < 7 && log_fill > 0)
            t.read_index = slt_pkg::INDEX_W'($urandom_range(0, log_fill - 1));
        else
            t.read_index = slt_pkg::INDEX_W'($urandom_range(0, 31));
        return t;
    endfunction

    task automatic send_txn(slt_pkg::t_in_item txn, bit fixed,
                            slt_pkg::t_out_item fixed_rep);
        slt_pkg::t_out_item predicted;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 16);
        end
        in_valid <= 1'b1;
        in_item  <= txn;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = apply_log_op(txn);
        due_reports.push_back(fixed ? fixed_rep : predicted);
        burst_left--;
    endtask

    // stop offering and let every report come back before touching config
    task automatic drain;
        in_valid   <= 1'b0;
        burst_left = 0;
        while (due_reports.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_config(logic [slt_pkg::LETTER_W-1:0] limit,
                              logic [slt_pkg::PRIO_W-1:0] thresh);
        cfg_we    <= 1'b1;
        cfg_index <= slt_pkg::CFG_LIMIT;
        cfg_data  <= slt_pkg::CFG_DATA_W'(limit);
        @(posedge clk);
        cfg_index <= slt_pkg::CFG_THRESH;
        cfg_data  <= slt_pkg::CFG_DATA_W'(thresh);
        @(posedge clk);
        cfg_we    <= 1'b0;
        crit_limit  = limit;
        purge_floor = thresh;
    endtask

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (due_reports.size() == 0) begin
                $display("%0t ns: report with no transaction outstanding, got %h",
                         $time, out_item);
                mismatches++;
            end else begin
                want_rep = due_reports.pop_front();
                check_field("status", want_rep.status, out_item.status);
                check_field("fill_level", want_rep.fill_level, out_item.fill_level);
                check_field("critical_total", want_rep.critical_total,
                            out_item.critical_total);
                check_field("normal_total", want_rep.normal_total, out_item.normal_total);
                check_field("out_letter", want_rep.out_letter, out_item.out_letter);
                check_field("out_number", want_rep.out_number, out_item.out_number);
                check_field("out_priority", want_rep.out_priority, out_item.out_priority);
                check_field("out_critical", want_rep.out_critical, out_item.out_critical);
                check_field("out_valid", want_rep.out_valid, out_item.out_valid);
            end
        end
    end

    // receiver backpressure: segments of no stall, random stall, heavy stall, toggling
    initial begin
        int kind, seg_len, n;
        forever begin
            if (want_long_hold) begin
                want_long_hold = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            kind    = $urandom_range(0, 3);
            seg_len = $urandom_range(1, 40);
            for (n = 0; n < seg_len; n++) begin
                case (kind)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= $urandom_range(0, 1);
                    2:       out_stall <= ($urandom_range(0, 7) != 0);
                    default: out_stall <= n[0];
                endcase
                @(posedge clk);
            end
        end
    end

    initial begin
        slt_pkg::t_out_item none;
        int ph, k;

        none = '0;
        // reset config: limit 4, threshold 300
        add_row(mk_txn(slt_pkg::OP_READ, 0, 0, 0, 0), 1, mk_report(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_txn(slt_pkg::OP_PURGE, 3, 11, 200, 5), 1,
                mk_report(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_txn(OP_SPARE, 31, 16383, 1023, 31), 1,
                mk_report(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_txn(slt_pkg::OP_INSERT, 0, 0, 0, 0), 1,
                mk_report(1, 1, 0, 0, 0, 0, 0, 0));
        add_row(mk_txn(slt_pkg::OP_INSERT, 31, 16383, 1023, 31), 1,
                mk_report(2, 1, 1, 0, 0, 0, 0, 0));
        add_row(mk_txn(slt_pkg::OP_INSERT, 25, 9999, 1000, 0), 1,
                mk_report(3, 1, 2, 0, 0, 0, 0, 0));
        // letter equal to the limit still counts as critical
        add_row(mk_txn(slt_pkg::OP_INSERT, 4, 1234, 500, 0), 1,
                mk_report(4, 2, 2, 0, 0, 0, 0, 0));
        add_row(mk_txn(slt_pkg::OP_INSERT, 5, 42, 500, 0), 1,
                mk_report(5, 2, 3, 0, 0, 0, 0, 0));
        // equal key lands behind, higher priority ahead
        add_row(mk_txn(slt_pkg::OP_INSERT, 4, 77, 500, 0), 0, none);
        add_row(mk_txn(slt_pkg::OP_INSERT, 4, 88, 700, 0), 0, none);
        add_row(mk_txn(slt_pkg::OP_READ, 9, 1, 1, 0), 1, mk_report(7, 4, 3, 0, 0, 0, 1, 1));
        add_row(mk_txn(slt_pkg::OP_READ, 0, 0, 0, 1), 0, none);
        add_row(mk_txn(slt_pkg::OP_READ, 0, 0, 0, 2), 0, none);
        add_row(mk_txn(slt_pkg::OP_READ, 0, 0, 0, 3), 0, none);
        add_row(mk_txn(slt_pkg::OP_READ, 0, 0, 0, 6), 1,
                mk_report(7, 4, 3, 31, 16383, 1023, 0, 1));
        // past the fill level
        add_row(mk_txn(slt_pkg::OP_READ, 0, 0, 0, 7), 1, mk_report(7, 4, 3, 0, 0, 0, 0, 0));
        add_row(mk_txn(slt_pkg::OP_READ, 0, 0, 0, 31), 1,
                mk_report(7, 4, 3, 0, 0, 0, 0, 0));
        add_row(mk_txn(OP_SPARE, 2, 3, 4, 0), 1, mk_report(7, 4, 3, 0, 0, 0, 0, 0));
        // one just below and one exactly at the purge threshold
        add_row(mk_txn(slt_pkg::OP_INSERT, 4, 5, 299, 0), 0, none);
        add_row(mk_txn(slt_pkg::OP_INSERT, 30, 1, 300, 0), 0, none);
        add_row(mk_txn(slt_pkg::OP_PURGE, 0, 0, 0, 0), 0, none);
        add_row(mk_txn(slt_pkg::OP_READ, 0, 0, 0, 0), 0, none);
        add_row(mk_txn(slt_pkg::OP_READ, 0, 0, 0, 6), 0, none);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_txn(dir_rows[k].txn, dir_rows[k].fixed, dir_rows[k].report);
        drain();

        for (ph = 0; ph < N_PHASES; ph++) begin
            set_config(slt_pkg::LETTER_W'(ph_limit[ph]), slt_pkg::PRIO_W'(ph_thresh[ph]));
            // hold the receiver off long enough for the table to back up its input
            if (ph == 0 || ph == 5)
                want_long_hold = 1'b1;
            for (k = 0; k < ph_items[ph]; k++)
                send_txn(rand_txn(ph_ins[ph]), 1'b0, none);
            drain();
        end

        if (mismatches == 0)
            $display("sorted_priority_log_table test passed");
        else
            $display("sorted_priority_log_table test failed");
        $finish;
    end

endmodule
